[src/nwa_pkg.sv]
// nwa_pkg: shared constants, action codes and controller/datapath structs
// for the nfa word acceptor; used by nwa_ctrl, nwa_dp and nfa_word_acceptor
`default_nettype none

package nwa_pkg;

  localparam int MAX_STATES    = 64;
  localparam int ALPHABET_SIZE = 32;

  localparam int STATE_W  = 6;
  localparam int SYM_W    = 5;
  localparam int ST_IDX_W = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int DEPTH    = MAX_STATES * ALPHABET_SIZE;
  localparam int ADDR_W   = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_MARK = 2'd1,
    ACT_WORD = 2'd2,
    ACT_EOW  = 2'd3
  } nwa_action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_SCAN,
    ST_COMMIT
  } nwa_state_e;

  typedef struct packed {
    logic capture;
    logic mark;
    logic eow;
    logic clr_step;
    logic add_rd;
    logic add_wr;
    logic scan_step;
    logic scan_commit;
  } nwa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_last;
    logic out_busy;
  } nwa_sts_t;

  function automatic logic [ADDR_W-1:0] nwa_addr(input logic [ST_IDX_W-1:0] st,
                                                 input logic [SYM_W-1:0]    sym);
    return ADDR_W'(st) * ADDR_W'(ALPHABET_SIZE) + ADDR_W'(sym);
  endfunction

endpackage

`default_nettype wire

[src/nfa_word_acceptor.sv]
// nfa_word_acceptor: top level joining nwa_ctrl and nwa_dp
// depends on nwa_pkg, nwa_ctrl, nwa_dp
//
// channel  direction  handshake                 payload
// input    in         in_valid_i / in_stall_o   action_i, from_state_i, to_state_i, symbol_i
// result   out        out_valid_o / out_stall_i accepted_o
//
// after reset the transition store is zeroed, one entry a cycle, with input stalled until all 2048 entries are clear
// add transition is a read-modify-write of one store entry: ST_ADD_RD reads it, ST_ADD_WR writes it back
// word symbol does one store read per state, MAX_STATES reads in ST_SCAN, between capture and ST_COMMIT
// mark accepting and end of word are done in ST_IDLE without leaving it
// one result register; in ST_IDLE, end of word stalls only while that register holds an untaken result
`default_nettype none

module nfa_word_acceptor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  action_i,
  input  logic [nwa_pkg::STATE_W-1:0] from_state_i,
  input  logic [nwa_pkg::STATE_W-1:0] to_state_i,
  input  logic [nwa_pkg::SYM_W-1:0]   symbol_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        accepted_o
);
  import nwa_pkg::*;

  nwa_cmd_t cmd;
  nwa_sts_t sts;

  nwa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nwa_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .from_state_i (from_state_i),
    .to_state_i   (to_state_i),
    .symbol_i     (symbol_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .accepted_o   (accepted_o)
  );

endmodule

`default_nettype wire

[src/nwa_ctrl.sv]
// nwa_ctrl: state machine sequencing clearing, transition updates and
// symbol scans; depends on nwa_pkg, drives nwa_dp through nwa_cmd_t
`default_nettype none

module nwa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        action_i,
  output logic              in_stall_o,
  input  nwa_pkg::nwa_sts_t sts_i,
  output nwa_pkg::nwa_cmd_t cmd_o
);
  import nwa_pkg::*;

  nwa_state_e  state_q, state_d;
  nwa_action_e act;
  logic        accept;

  assign act = nwa_action_e'(action_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    accept     = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = (act == ACT_EOW) && sts_i.out_busy;
        accept     = in_valid_i && !in_stall_o;
        if (accept) begin
          cmd_o.capture = 1'b1;
          case (act)
            ACT_ADD:  state_d = ST_ADD_RD;
            ACT_MARK: cmd_o.mark = 1'b1;
            ACT_WORD: state_d = ST_SCAN;
            ACT_EOW:  cmd_o.eow = 1'b1;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD_RD: begin
        cmd_o.add_rd = 1'b1;
        state_d      = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd_o.scan_commit = 1'b1;
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.add_wr |-> $past(cmd_o.add_rd))
    else $error("transition write without preceding read");

  a_commit_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_commit |-> $past(cmd_o.scan_step && sts_i.scan_last))
    else $error("commit without completed scan");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.mark, cmd_o.eow, cmd_o.clr_step, cmd_o.add_rd,
              cmd_o.add_wr, cmd_o.scan_step, cmd_o.scan_commit}))
    else $error("conflicting datapath commands");

  a_eow_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.eow |-> !sts_i.out_busy)
    else $error("end of word while result register blocked");

endmodule

`default_nettype wire

[src/nwa_dp.sv]
// nwa_dp: transition store, accepting mask, active set and result register
// of the nfa word acceptor; depends on nwa_pkg, driven by nwa_ctrl
`default_nettype none

module nwa_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [nwa_pkg::STATE_W-1:0]  from_state_i,
  input  logic [nwa_pkg::STATE_W-1:0]  to_state_i,
  input  logic [nwa_pkg::SYM_W-1:0]    symbol_i,
  input  nwa_pkg::nwa_cmd_t            cmd_i,
  output nwa_pkg::nwa_sts_t            sts_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         accepted_o
);
  import nwa_pkg::*;

  logic [MAX_STATES-1:0] mem [DEPTH];
  logic [MAX_STATES-1:0] rdata_q;
  logic [ADDR_W-1:0]     raddr, waddr;
  logic [MAX_STATES-1:0] wdata;
  logic                  we;

  logic [STATE_W-1:0]    from_q, to_q;
  logic [SYM_W-1:0]      sym_q;
  logic                  add_ok_q, sym_ok_q;

  logic [ADDR_W-1:0]     clr_cnt_q;
  logic [ST_IDX_W-1:0]   scan_cnt_q;
  logic                  tag_q;
  logic [MAX_STATES-1:0] active_q, next_q, accepting_q, contrib;
  logic                  out_full_q, out_acc_q;
  logic                  from_ok_i;

  assign from_ok_i = 32'(from_state_i) < 32'(MAX_STATES);
  assign contrib   = tag_q ? rdata_q : '0;

  assign raddr = cmd_i.scan_step ? nwa_addr(scan_cnt_q, sym_q)
                                 : nwa_addr(from_q[ST_IDX_W-1:0], sym_q);

  always_comb begin
    we    = 1'b0;
    waddr = nwa_addr(from_q[ST_IDX_W-1:0], sym_q);
    wdata = rdata_q | (MAX_STATES'(1) << to_q[ST_IDX_W-1:0]);
    if (cmd_i.clr_step) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = '0;
    end else if (cmd_i.add_wr && add_ok_q) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      from_q   <= from_state_i;
      to_q     <= to_state_i;
      sym_q    <= symbol_i;
      add_ok_q <= from_ok_i && (32'(to_state_i) < 32'(MAX_STATES))
                  && (32'(symbol_i) < 32'(ALPHABET_SIZE));
      sym_ok_q <= 32'(symbol_i) < 32'(ALPHABET_SIZE);
    end
    if (cmd_i.eow) begin
      out_acc_q <= |(active_q & accepting_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      scan_cnt_q  <= '0;
      tag_q       <= 1'b0;
      active_q    <= MAX_STATES'(1);
      next_q      <= '0;
      accepting_q <= '0;
      out_full_q  <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      tag_q <= cmd_i.scan_step && active_q[scan_cnt_q] && sym_ok_q;
      if (cmd_i.capture) begin
        scan_cnt_q <= '0;
        next_q     <= '0;
      end else if (cmd_i.scan_step) begin
        scan_cnt_q <= scan_cnt_q + 1'b1;
        next_q     <= next_q | contrib;
      end else if (cmd_i.scan_commit) begin
        next_q   <= next_q | contrib;
        active_q <= next_q | contrib;
      end
      if (cmd_i.mark && from_ok_i) begin
        accepting_q <= accepting_q | (MAX_STATES'(1) << from_state_i[ST_IDX_W-1:0]);
      end
      if (cmd_i.eow) begin
        active_q   <= MAX_STATES'(1);
        out_full_q <= 1'b1;
      end else if (out_full_q && !out_stall_i) begin
        out_full_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_last  = clr_cnt_q == ADDR_W'(DEPTH - 1);
  assign sts_o.scan_last = scan_cnt_q == ST_IDX_W'(MAX_STATES - 1);
  assign sts_o.out_busy  = out_full_q && out_stall_i;

  assign out_valid_o = out_full_q;
  assign accepted_o  = out_acc_q;

  a_scan_idle_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_q |-> $past(cmd_i.scan_step))
    else $error("successor data tagged outside a scan");

  a_eow_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.eow |=> (active_q == MAX_STATES'(1)) && out_full_q)
    else $error("end of word did not reload active set");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_full_q && out_stall_i && !cmd_i.eow) |=> out_full_q && $stable(out_acc_q))
    else $error("pending result lost");

endmodule

`default_nettype wire
